>>> src/mpbm_pkg.sv
// Shared constants, types and helper codes of the multi-pattern byte matcher.
package mpbm_pkg;

  localparam int NODES   = 256;
  localparam int TOKENS  = 64;
  localparam int MAX_RES = 64;

  localparam int NW = $clog2(NODES);
  localparam int TW = $clog2(TOKENS);
  localparam int HW = $clog2(NODES + 1);
  localparam int RW = $clog2(MAX_RES + 1);

  localparam logic [2:0] OP_TEXT = 3'd0;
  localparam logic [2:0] OP_GOTO = 3'd1;
  localparam logic [2:0] OP_LINK = 3'd2;
  localparam logic [2:0] OP_LIST = 3'd3;
  localparam logic [2:0] OP_TOK  = 3'd4;
  localparam logic [2:0] OP_LEN  = 3'd5;

  typedef enum logic [2:0] {
    K_TEXT,
    K_GOTO,
    K_LINK,
    K_LIST,
    K_TOK,
    K_LEN
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       new_text;
    logic [7:0] entry_index;
    logic [7:0] value_a;
    logic [7:0] value_b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

>>> src/mpbm_front.sv
// Request intake: decodes op codes and queues requests for the walker.
module mpbm_front import mpbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       new_text_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] value_a_i,
  input  logic [7:0] value_b_i,
  input  logic       pop_i,
  output queue_out_t head_o
);

  item_t       slot_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       item;
  logic        keep;
  logic        push, pop;

  always_comb begin
    item.data_byte   = data_byte_i;
    item.new_text    = new_text_i;
    item.entry_index = entry_index_i;
    item.value_a     = value_a_i;
    item.value_b     = value_b_i;
    item.kind        = K_TEXT;
    keep             = 1'b1;
    unique case (op_i)
      OP_TEXT: item.kind = K_TEXT;
      OP_GOTO: item.kind = K_GOTO;
      OP_LINK: item.kind = K_LINK;
      OP_LIST: item.kind = K_LIST;
      OP_TOK:  item.kind = K_TOK;
      OP_LEN:  item.kind = K_LEN;
      default: keep = 1'b0;
    endcase
  end

  assign busy  = (cnt_q == 2'd2);
  assign push  = start && !busy && keep;
  assign pop   = pop_i && (cnt_q != 2'd0);
  assign wr_d  = push ? !wr_q : wr_q;
  assign rd_d  = pop ? !rd_q : rd_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item;
    end
  end

endmodule

>>> src/mpbm_back.sv
// Automaton tables and the walker that follows failure and output links.
module mpbm_back import mpbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_out_t  head_i,
  output logic        pop_o,
  output logic        result_valid_o,
  output logic [5:0]  token_id_o,
  output logic [31:0] token_start_o,
  output logic [31:0] token_end_o,
  output logic        last_o
);

  localparam int GW = NW + 8;
  localparam int SW = TW + 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GOTO  = 3'd1;
  localparam logic [2:0] S_FAIL  = 3'd2;
  localparam logic [2:0] S_ONODE = 3'd3;
  localparam logic [2:0] S_OLIST = 3'd4;
  localparam logic [2:0] S_KLOOP = 3'd5;
  localparam logic [2:0] S_TOK   = 3'd6;
  localparam logic [2:0] S_LEN   = 3'd7;

  logic [NW-1:0]   goto_mem [NODES*256];
  logic [2*NW-1:0] link_mem [NODES];
  logic [TW+7:0]   list_mem [NODES];
  logic [7:0]      tok_mem  [TOKENS];
  logic [7:0]      len_mem  [TOKENS];

  logic [NW-1:0]   goto_rd;
  logic [2*NW-1:0] link_rd;
  logic [TW+7:0]   list_rd;
  logic [7:0]      tok_rd;
  logic [7:0]      len_rd;

  logic [GW-1:0]   goto_a;
  logic [NW-1:0]   link_a, list_a;
  logic [TW-1:0]   tok_a, len_a;
  logic            goto_we, link_we, list_we, tok_we, len_we;

  logic [2:0]      state_q, state_d;
  logic [NW-1:0]   cur_q, cur_d, node_q, node_d, o_q, o_d;
  logic [31:0]     pos_q, pos_d, end_q, end_d;
  logic [7:0]      byte_q, byte_d;
  logic [HW-1:0]   hops_q, hops_d;
  logic [RW-1:0]   n_q, n_d;
  logic [TW-1:0]   first_q, first_d;
  logic [7:0]      cnt_q, cnt_d, k_q, k_d, id_q, id_d;
  logic            pend_v_q, pend_v_d;
  logic [5:0]      pend_id_q, pend_id_d;
  logic [31:0]     pend_st_q, pend_st_d;
  logic            ov_q, ov_d, olast_q, olast_d;
  logic [5:0]      oid_q, oid_d;
  logic [31:0]     ost_q, ost_d, oend_q, oend_d;

  item_t           it;
  logic [NW-1:0]   tgt, fnode, ia_node, va_node, vb_node;
  logic [NW-1:0]   start_node;

  assign it      = head_i.item;
  assign tgt     = goto_rd;
  assign fnode   = link_rd[2*NW-1:NW];
  assign ia_node = NW'(it.entry_index % NODES);
  assign va_node = NW'(it.value_a % NODES);
  assign vb_node = NW'(it.value_b % NODES);
  assign start_node = it.new_text ? '0 : cur_q;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    node_d    = node_q;
    o_d       = o_q;
    pos_d     = pos_q;
    end_d     = end_q;
    byte_d    = byte_q;
    hops_d    = hops_q;
    n_d       = n_q;
    first_d   = first_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    id_d      = id_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    pend_st_d = pend_st_q;
    ov_d      = 1'b0;
    olast_d   = olast_q;
    oid_d     = oid_q;
    ost_d     = ost_q;
    oend_d    = oend_q;
    pop_o     = 1'b0;
    goto_a    = {node_q, byte_q};
    link_a    = node_q;
    list_a    = o_q;
    tok_a     = TW'(SW'(first_q) + SW'(k_q));
    len_a     = TW'(tok_rd % TOKENS);
    goto_we   = 1'b0;
    link_we   = 1'b0;
    list_we   = 1'b0;
    tok_we    = 1'b0;
    len_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (it.kind)
            K_TEXT: begin
              if (it.new_text) begin
                pos_d = '0;
              end
              node_d  = start_node;
              byte_d  = it.data_byte;
              goto_a  = {start_node, it.data_byte};
              hops_d  = '0;
              state_d = S_GOTO;
            end
            K_GOTO: begin
              goto_a  = {ia_node, it.data_byte};
              goto_we = 1'b1;
            end
            K_LINK: begin
              link_a  = ia_node;
              link_we = 1'b1;
            end
            K_LIST: begin
              list_a  = ia_node;
              list_we = 1'b1;
            end
            K_TOK: begin
              tok_a  = TW'(it.entry_index % TOKENS);
              tok_we = 1'b1;
            end
            K_LEN: begin
              len_a  = TW'(it.entry_index % TOKENS);
              len_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_GOTO: begin
        if (tgt != '0) begin
          cur_d   = tgt;
          o_d     = tgt;
          pos_d   = pos_q + 32'd1;
          end_d   = pos_q + 32'd1;
          hops_d  = '0;
          n_d     = '0;
          state_d = S_ONODE;
        end else if (node_q == '0 || hops_q == HW'(NODES)) begin
          cur_d   = '0;
          pos_d   = pos_q + 32'd1;
          state_d = S_IDLE;
        end else begin
          link_a  = node_q;
          hops_d  = hops_q + HW'(1);
          state_d = S_FAIL;
        end
      end
      S_FAIL: begin
        node_d  = fnode;
        goto_a  = {fnode, byte_q};
        state_d = S_GOTO;
      end
      S_ONODE: begin
        if (o_q == '0 || hops_q == HW'(NODES) || n_q == RW'(MAX_RES)) begin
          if (pend_v_q) begin
            ov_d    = 1'b1;
            olast_d = 1'b1;
            oid_d   = pend_id_q;
            ost_d   = pend_st_q;
            oend_d  = end_q;
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end else begin
          link_a  = o_q;
          list_a  = o_q;
          state_d = S_OLIST;
        end
      end
      S_OLIST: begin
        first_d = list_rd[TW+7:8];
        cnt_d   = list_rd[7:0];
        o_d     = link_rd[NW-1:0];
        hops_d  = hops_q + HW'(1);
        k_d     = '0;
        state_d = S_KLOOP;
      end
      S_KLOOP: begin
        if (k_q < cnt_q && n_q != RW'(MAX_RES)) begin
          k_d     = k_q + 8'd1;
          state_d = S_TOK;
        end else begin
          state_d = S_ONODE;
        end
      end
      S_TOK: begin
        id_d    = tok_rd;
        state_d = S_LEN;
      end
      S_LEN: begin
        if (pend_v_q) begin
          ov_d    = 1'b1;
          olast_d = 1'b0;
          oid_d   = pend_id_q;
          ost_d   = pend_st_q;
          oend_d  = end_q;
        end
        pend_v_d  = 1'b1;
        pend_id_d = id_q[5:0];
        pend_st_d = end_q - {24'd0, len_rd};
        n_d       = n_q + RW'(1);
        state_d   = S_KLOOP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) begin
      goto_mem[goto_a] <= va_node;
    end
    goto_rd <= goto_mem[goto_a];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_a] <= {va_node, vb_node};
    end
    link_rd <= link_mem[link_a];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_a] <= {TW'(it.value_a % TOKENS), it.value_b};
    end
    list_rd <= list_mem[list_a];
  end

  always_ff @(posedge clk_i) begin
    if (tok_we) begin
      tok_mem[tok_a] <= it.value_a;
    end
    tok_rd <= tok_mem[tok_a];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_a] <= it.value_a;
    end
    len_rd <= len_mem[len_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_q    <= '0;
      pos_q    <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      pos_q    <= pos_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    o_q       <= o_d;
    end_q     <= end_d;
    byte_q    <= byte_d;
    hops_q    <= hops_d;
    n_q       <= n_d;
    first_q   <= first_d;
    cnt_q     <= cnt_d;
    k_q       <= k_d;
    id_q      <= id_d;
    pend_id_q <= pend_id_d;
    pend_st_q <= pend_st_d;
    olast_q   <= olast_d;
    oid_q     <= oid_d;
    ost_q     <= ost_d;
    oend_q    <= oend_d;
  end

  assign result_valid_o = ov_q;
  assign token_id_o     = oid_q;
  assign token_start_o  = ost_q;
  assign token_end_o    = oend_q;
  assign last_o         = olast_q;

endmodule

>>> src/multi_pattern_byte_matcher.sv
// Top level of the multi-pattern byte matcher: request queue and walker.
//
// Requests enter on start when busy is low; op_i selects a text byte or one
// of the table loads (goto edge, fail/output link, output list, list token,
// token length). Op codes 6 and 7 are taken and dropped.
// A two-entry queue sits between intake and walker, so a new request is
// taken while the walker is still busy; busy rises only when it is full.
// A load is written in the walker's idle state. A text byte does a goto
// lookup (S_GOTO), and on a miss a failure hop (S_FAIL) per retry, then
// reads each output-chain node (S_ONODE, S_OLIST) and each emitted match
// (S_KLOOP, S_TOK, S_LEN) from the tables, and closes back to idle.
// Each match is shown for one cycle on result_valid_o with token_id_o,
// token_start_o, token_end_o and last_o; last_o marks the final match of
// the byte. The receiver cannot stall, so results are never held back.
// Reset clears the queue, the walker, the current node and the position;
// tables keep no reset value and must be loaded before text is sent.
module multi_pattern_byte_matcher import mpbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        new_text_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  value_a_i,
  input  logic [7:0]  value_b_i,
  output logic        result_valid_o,
  output logic [5:0]  token_id_o,
  output logic [31:0] token_start_o,
  output logic [31:0] token_end_o,
  output logic        last_o
);

  queue_out_t head;
  logic       pop;

  mpbm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .new_text_i    (new_text_i),
    .entry_index_i (entry_index_i),
    .value_a_i     (value_a_i),
    .value_b_i     (value_b_i),
    .pop_i         (pop),
    .head_o        (head)
  );

  mpbm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .token_id_o     (token_id_o),
    .token_start_o  (token_start_o),
    .token_end_o    (token_end_o),
    .last_o         (last_o)
  );

endmodule

>>> src/mpbm_checker.sv
// Port-level checks of the multi-pattern byte matcher and their binding.
module mpbm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic result_valid_o
);

  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results on adjacent cycles");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid_o)
    else $error("result right after reset");

  a_reset_free: assert property (@(posedge clk_i)
    !rst_ni |=> !busy)
    else $error("busy right after reset");

endmodule

bind multi_pattern_byte_matcher mpbm_checker u_mpbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
